// ----- rtl/command_line_tokenizer_assert.svh -----
// ----------------------------------------------------------------------------
// Command line tokenizer assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define COMMAND_LINE_TOKENIZER_ASSERT_SVH

// The expression holds at every clock edge.
`define CLT_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("command_line_tokenizer: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define CLT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("command_line_tokenizer: implication violated");

// The consequent holds in the cycle after the antecedent.
`define CLT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("command_line_tokenizer: next-cycle implication violated");

`endif

// ----- rtl/clt_pkg.sv -----
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Item types, token kind codes, error codes and character constants.
// ----------------------------------------------------------------------------
package clt_pkg;

  // Longest line that is scanned; later bytes are dropped.
  localparam int MAX_LINE = 1024;
  localparam int POS_W    = 10;  // byte offset within a line
  localparam int LEN_W    = 11;  // token length and line position

  // Result queue sizing: one byte can produce at most four results.
  localparam int PUSH_MAX   = 4;
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_line;
  } in_item_t;

  typedef struct packed {
    logic [5:0]       token_kind;
    logic [POS_W-1:0] start_pos;
    logic [LEN_W-1:0] token_length;
    logic [1:0]       dataset_kind;
    logic [15:0]      dataset_index;
    logic [2:0]       error_code;
    logic             last_of_line;
  } out_item_t;

  // Token kinds.
  localparam logic [5:0] K_NOP      = 6'd0;
  localparam logic [5:0] K_LNAME    = 6'd1;
  localparam logic [5:0] K_CNAME    = 6'd2;
  localparam logic [5:0] K_ULETTER  = 6'd3;
  localparam logic [5:0] K_STRING   = 6'd4;
  localparam logic [5:0] K_VARNAME  = 6'd5;
  localparam logic [5:0] K_FUNCNAME = 6'd6;
  localparam logic [5:0] K_NUMBER   = 6'd7;
  localparam logic [5:0] K_DATASET  = 6'd8;
  localparam logic [5:0] K_LE       = 6'd9;
  localparam logic [5:0] K_GE       = 6'd10;
  localparam logic [5:0] K_NE       = 6'd11;
  localparam logic [5:0] K_EQ       = 6'd12;
  localparam logic [5:0] K_APPEND   = 6'd13;
  localparam logic [5:0] K_DOTS     = 6'd14;
  localparam logic [5:0] K_PM       = 6'd15;
  localparam logic [5:0] K_ADDA     = 6'd16;
  localparam logic [5:0] K_SUBA     = 6'd17;
  localparam logic [5:0] K_OPEN     = 6'd18;
  localparam logic [5:0] K_CLOSE    = 6'd19;
  localparam logic [5:0] K_LSQ      = 6'd20;
  localparam logic [5:0] K_RSQ      = 6'd21;
  localparam logic [5:0] K_LCUR     = 6'd22;
  localparam logic [5:0] K_RCUR     = 6'd23;
  localparam logic [5:0] K_PLUS     = 6'd24;
  localparam logic [5:0] K_MINUS    = 6'd25;
  localparam logic [5:0] K_MULT     = 6'd26;
  localparam logic [5:0] K_DIV      = 6'd27;
  localparam logic [5:0] K_POW      = 6'd28;
  localparam logic [5:0] K_LT       = 6'd29;
  localparam logic [5:0] K_GT       = 6'd30;
  localparam logic [5:0] K_ASSIGN   = 6'd31;
  localparam logic [5:0] K_COMMA    = 6'd32;
  localparam logic [5:0] K_SEMI     = 6'd33;
  localparam logic [5:0] K_DOT      = 6'd34;
  localparam logic [5:0] K_COLON    = 6'd35;
  localparam logic [5:0] K_TILDE    = 6'd36;
  localparam logic [5:0] K_QMARK    = 6'd37;
  localparam logic [5:0] K_BANG     = 6'd38;

  // Error codes.
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_STRING   = 3'd1;
  localparam logic [2:0] E_AT       = 3'd2;
  localparam logic [2:0] E_VAR      = 3'd3;
  localparam logic [2:0] E_FUNC     = 3'd4;
  localparam logic [2:0] E_BAD_CHAR = 3'd5;

  // Dataset kinds.
  localparam logic [1:0] DK_NUM = 2'd0;
  localparam logic [1:0] DK_ALL = 2'd1;
  localparam logic [1:0] DK_NEW = 2'd2;

  // Character codes.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_QUOTE   = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_COMMA   = 8'h2C;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LT      = 8'h3C;
  localparam logic [7:0] CH_EQ      = 8'h3D;
  localparam logic [7:0] CH_GT      = 8'h3E;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UE      = 8'h45;
  localparam logic [7:0] CH_UZ      = 8'h5A;
  localparam logic [7:0] CH_LSQ     = 8'h5B;
  localparam logic [7:0] CH_RSQ     = 8'h5D;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_USCORE  = 8'h5F;
  localparam logic [7:0] CH_LA      = 8'h61;
  localparam logic [7:0] CH_LE      = 8'h65;
  localparam logic [7:0] CH_LZ      = 8'h7A;
  localparam logic [7:0] CH_LCUR    = 8'h7B;
  localparam logic [7:0] CH_RCUR    = 8'h7D;
  localparam logic [7:0] CH_TILDE   = 8'h7E;

endpackage

// ----- rtl/command_line_tokenizer.sv -----
// ----------------------------------------------------------------------------
// Command line tokenizer
// Byte-at-a-time lexical scanner that turns a command line into tokens.
// ----------------------------------------------------------------------------
`include "command_line_tokenizer_assert.svh"

// Each input item is one byte of a command line, or an end-of-line marker.
// The block accepts one item per clock cycle while the queue has room: an
// item is captured in an input register, and a single pass of scan logic
// then updates the scanner state and writes the tokens that the byte
// completes into an eight-entry result queue. A byte completes at most four
// results (a number whose dangling exponent is backed off can end a number,
// a name and an operator together), so a new item is taken whenever the
// queue holds four results or fewer; the queue hands out one result per
// cycle while out_ready is high. Results pass through the input register
// and the result queue before they are offered. Results come out in line
// order, and every end-of-line marker closes the line with a Nop result
// that has last_of_line set. Bytes at offset MAX_LINE and beyond are
// dropped, and after an error or a comment the rest of the line is skipped.
module command_line_tokenizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  clt_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output clt_pkg::out_item_t  out_data
);

  import clt_pkg::*;

  // Scanner modes: what kind of token the scanner is currently inside.
  typedef enum logic [4:0] {
    M_IDLE, M_LNAME, M_UPPER, M_CNAME, M_STRING, M_VAR0, M_VAR, M_FUNC0,
    M_FUNC, M_GT, M_LT, M_EQ, M_PLUS, M_MINUS, M_BANG, M_DOT, M_DOTS, M_AT,
    M_ATNUM, M_INT, M_FRAC, M_EXP
  } mode_t;

  // Everything the scanner carries from one byte to the next. The exponent
  // letter and its sign are kept as one bit each, since only the case of
  // the letter and the sign's polarity matter when they are backed off.
  typedef struct packed {
    mode_t            mode;
    logic [POS_W-1:0] ts;          // start offset of the open token
    logic [15:0]      acc;         // dataset number, saturating
    logic [1:0]       bo;          // exponent bytes that may need back-off
    logic             skip;        // rest of line is ignored
    logic             exp_up;      // exponent letter was 'E'
    logic             sign_minus;  // exponent sign was '-'
    logic [POS_W-1:0] nop;         // offset reported by the closing Nop
  } scan_st_t;

  // Outcome of one scan step: new state and up to two results, in order.
  typedef struct packed {
    scan_st_t  st;
    logic [1:0] n;
    out_item_t r0;
    out_item_t r1;
  } step_t;

  localparam scan_st_t ST_RESET = '{mode: M_IDLE, ts: '0, acc: '0, bo: '0,
                                    skip: 1'b0, exp_up: 1'b0,
                                    sign_minus: 1'b0, nop: '0};

  // --------------------------------------------------------------------------
  // Character classes
  // --------------------------------------------------------------------------
  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_upper(logic [7:0] c);
    return (c >= CH_UA) && (c <= CH_UZ);
  endfunction

  function automatic logic is_lower(logic [7:0] c);
    return (c >= CH_LA) && (c <= CH_LZ);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return is_upper(c) || is_lower(c);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // --------------------------------------------------------------------------
  // Result builders
  // --------------------------------------------------------------------------
  function automatic out_item_t mk_item(logic [5:0] kind, logic [POS_W-1:0] start,
                                        logic [LEN_W-1:0] len, logic [1:0] dk,
                                        logic [15:0] di, logic [2:0] err,
                                        logic last);
    out_item_t o;
    o.token_kind    = kind;
    o.start_pos     = start;
    o.token_length  = len;
    o.dataset_kind  = dk;
    o.dataset_index = di;
    o.error_code    = err;
    o.last_of_line  = last;
    return o;
  endfunction

  function automatic out_item_t mk_tok(logic [5:0] kind, logic [POS_W-1:0] start,
                                       logic [LEN_W-1:0] len);
    return mk_item(kind, start, len, DK_NUM, 16'd0, E_NONE, 1'b0);
  endfunction

  // Kind of a token that is complete after its single character.
  function automatic logic [5:0] single_kind(logic [7:0] c);
    logic [5:0] k;
    unique case (c)
      CH_LPAREN: k = K_OPEN;
      CH_RPAREN: k = K_CLOSE;
      CH_LSQ:    k = K_LSQ;
      CH_RSQ:    k = K_RSQ;
      CH_LCUR:   k = K_LCUR;
      CH_RCUR:   k = K_RCUR;
      CH_STAR:   k = K_MULT;
      CH_SLASH:  k = K_DIV;
      CH_CARET:  k = K_POW;
      CH_COMMA:  k = K_COMMA;
      CH_SEMI:   k = K_SEMI;
      CH_COLON:  k = K_COLON;
      CH_TILDE:  k = K_TILDE;
      CH_QMARK:  k = K_QMARK;
      default:   k = K_NOP;
    endcase
    return k;
  endfunction

  // Kind reported when an open token is ended by a byte it cannot take.
  function automatic logic [5:0] ending_kind(mode_t m);
    logic [5:0] k;
    unique case (m)
      M_LNAME:                 k = K_LNAME;
      M_UPPER:                 k = K_ULETTER;
      M_CNAME:                 k = K_CNAME;
      M_VAR:                   k = K_VARNAME;
      M_FUNC:                  k = K_FUNCNAME;
      M_GT:                    k = K_GT;
      M_LT:                    k = K_LT;
      M_EQ:                    k = K_ASSIGN;
      M_PLUS:                  k = K_PLUS;
      M_MINUS:                 k = K_MINUS;
      M_BANG:                  k = K_BANG;
      M_DOT:                   k = K_DOT;
      M_DOTS:                  k = K_DOTS;
      M_INT, M_FRAC, M_EXP:    k = K_NUMBER;
      default:                 k = K_NOP;
    endcase
    return k;
  endfunction

  // --------------------------------------------------------------------------
  // Scan steps
  // --------------------------------------------------------------------------

  // A byte seen between tokens: opens a token, emits a one-character token,
  // starts a comment or reports an unexpected character.
  function automatic step_t start_char(scan_st_t s, logic [7:0] c,
                                       logic [POS_W-1:0] pos);
    step_t      r;
    logic [5:0] k;
    r.st      = s;
    r.n       = 2'd0;
    r.r0      = '0;
    r.r1      = '0;
    r.st.ts   = pos;
    r.st.mode = M_IDLE;
    k         = single_kind(c);
    if (is_space(c)) begin
      r.n = 2'd0;
    end else if ((c == CH_NUL) || (c == CH_HASH)) begin
      r.st.skip = 1'b1;
      r.st.nop  = pos;
    end else if (k != K_NOP) begin
      r.n  = 2'd1;
      r.r0 = mk_tok(k, pos, LEN_W'(1));
    end else begin
      unique case (c)
        CH_QUOTE:   r.st.mode = M_STRING;
        CH_GT:      r.st.mode = M_GT;
        CH_LT:      r.st.mode = M_LT;
        CH_EQ:      r.st.mode = M_EQ;
        CH_PLUS:    r.st.mode = M_PLUS;
        CH_MINUS:   r.st.mode = M_MINUS;
        CH_BANG:    r.st.mode = M_BANG;
        CH_DOT:     r.st.mode = M_DOT;
        CH_DOLLAR:  r.st.mode = M_VAR0;
        CH_PERCENT: r.st.mode = M_FUNC0;
        CH_AT: begin
          r.st.acc  = 16'd0;
          r.st.mode = M_AT;
        end
        default: begin
          if (is_digit(c)) begin
            r.st.mode = M_INT;
          end else if (is_upper(c)) begin
            r.st.mode = M_UPPER;
          end else if (is_lower(c) || (c == CH_USCORE)) begin
            r.st.mode = M_LNAME;
          end else begin
            r.n       = 2'd1;
            r.r0      = mk_item(K_NOP, pos, LEN_W'(1), DK_NUM, 16'd0, E_BAD_CHAR, 1'b0);
            r.st.skip = 1'b1;
            r.st.nop  = pos;
          end
        end
      endcase
    end
    return r;
  endfunction

  function automatic step_t fail_at(scan_st_t s, logic [2:0] code,
                                    logic [POS_W-1:0] pos, logic [LEN_W-1:0] len);
    step_t r;
    r.st      = s;
    r.n       = 2'd1;
    r.r0      = mk_item(K_NOP, s.ts, len, DK_NUM, 16'd0, code, 1'b0);
    r.r1      = '0;
    r.st.skip = 1'b1;
    r.st.nop  = pos;
    r.st.mode = M_IDLE;
    return r;
  endfunction

  function automatic step_t emit_now(scan_st_t s, logic [5:0] kind,
                                     logic [LEN_W-1:0] len);
    step_t r;
    r.st      = s;
    r.st.mode = M_IDLE;
    r.n       = 2'd1;
    r.r0      = mk_tok(kind, s.ts, len);
    r.r1      = '0;
    return r;
  endfunction

  // Closes the open token with the given result, then treats the byte as
  // the first byte of whatever follows.
  function automatic step_t push_then_start(scan_st_t s, out_item_t item,
                                            logic [7:0] c, logic [POS_W-1:0] pos);
    step_t r;
    step_t sc;
    sc   = start_char(s, c, pos);
    r    = sc;
    r.n  = sc.n + 2'd1;
    r.r0 = item;
    r.r1 = sc.r0;
    return r;
  endfunction

  // One byte inside a line, with the scanner in any mode.
  function automatic step_t scan(scan_st_t s, logic [7:0] c, logic [POS_W-1:0] pos);
    step_t            r;
    logic             ends;
    logic [LEN_W-1:0] len0;
    logic [LEN_W-1:0] len1;
    logic [19:0]      acc10;
    r.st  = s;
    r.n   = 2'd0;
    r.r0  = '0;
    r.r1  = '0;
    ends  = 1'b0;
    len0  = {1'b0, pos} - {1'b0, s.ts};
    len1  = len0 + LEN_W'(1);
    acc10 = ({4'd0, s.acc} << 3) + ({4'd0, s.acc} << 1) + {16'd0, c[3:0]};
    unique case (s.mode)
      M_IDLE: r = start_char(s, c, pos);
      M_LNAME, M_VAR, M_FUNC: ends = !(is_alnum(c) || (c == CH_USCORE));
      M_UPPER: begin
        if (is_alnum(c)) r.st.mode = M_CNAME;
        else ends = 1'b1;
      end
      M_CNAME: ends = !is_alnum(c);
      M_STRING: begin
        if (c == CH_QUOTE) r = emit_now(s, K_STRING, len1);
        else if (c == CH_NUL) r = fail_at(s, E_STRING, pos, len0);
      end
      M_VAR0: begin
        if (is_alpha(c) || (c == CH_USCORE)) r.st.mode = M_VAR;
        else r = fail_at(s, E_VAR, pos, len0);
      end
      M_FUNC0: begin
        if (is_alpha(c) || (c == CH_USCORE)) r.st.mode = M_FUNC;
        else r = fail_at(s, E_FUNC, pos, len0);
      end
      M_GT: begin
        if (c == CH_EQ) r = emit_now(s, K_GE, len1);
        else if (c == CH_GT) r = emit_now(s, K_APPEND, len1);
        else ends = 1'b1;
      end
      M_LT: begin
        if (c == CH_EQ) r = emit_now(s, K_LE, len1);
        else if (c == CH_GT) r = emit_now(s, K_NE, len1);
        else ends = 1'b1;
      end
      M_EQ: begin
        if (c == CH_EQ) r = emit_now(s, K_EQ, len1);
        else ends = 1'b1;
      end
      M_PLUS: begin
        if (c == CH_MINUS) r = emit_now(s, K_PM, len1);
        else if (c == CH_EQ) r = emit_now(s, K_ADDA, len1);
        else ends = 1'b1;
      end
      M_MINUS: begin
        if (c == CH_EQ) r = emit_now(s, K_SUBA, len1);
        else ends = 1'b1;
      end
      M_BANG: begin
        if (c == CH_EQ) r = emit_now(s, K_NE, len1);
        else ends = 1'b1;
      end
      M_DOT: begin
        if (is_digit(c)) r.st.mode = M_FRAC;
        else if (c == CH_DOT) r.st.mode = M_DOTS;
        else ends = 1'b1;
      end
      M_DOTS: begin
        if (c == CH_DOT) r = emit_now(s, K_DOTS, len1);
        else ends = 1'b1;
      end
      M_AT: begin
        if ((c == CH_STAR) || (c == CH_PLUS)) begin
          r.n       = 2'd1;
          r.r0      = mk_item(K_DATASET, s.ts, LEN_W'(2),
                              (c == CH_STAR) ? DK_ALL : DK_NEW, 16'd0, E_NONE, 1'b0);
          r.st.mode = M_IDLE;
        end else if (is_digit(c)) begin
          r.st.acc  = {12'd0, c[3:0]};
          r.st.mode = M_ATNUM;
        end else begin
          r = fail_at(s, E_AT, pos, len0);
        end
      end
      M_ATNUM: begin
        if (is_digit(c)) begin
          r.st.acc = (acc10 > 20'd65535) ? 16'hFFFF : acc10[15:0];
        end else begin
          r = push_then_start(s, mk_item(K_DATASET, s.ts, len0, DK_NUM, s.acc,
                                         E_NONE, 1'b0), c, pos);
        end
      end
      M_INT: begin
        if (is_digit(c)) begin
          r.n = 2'd0;
        end else if (c == CH_DOT) begin
          r.st.mode = M_FRAC;
        end else if ((c == CH_LE) || (c == CH_UE)) begin
          r.st.mode   = M_EXP;
          r.st.bo     = 2'd1;
          r.st.exp_up = (c == CH_UE);
        end else begin
          ends = 1'b1;
        end
      end
      M_FRAC: begin
        if (is_digit(c)) begin
          r.n = 2'd0;
        end else if ((c == CH_LE) || (c == CH_UE)) begin
          r.st.mode   = M_EXP;
          r.st.bo     = 2'd1;
          r.st.exp_up = (c == CH_UE);
        end else begin
          ends = 1'b1;
        end
      end
      M_EXP: begin
        if (is_digit(c)) begin
          r.st.bo = 2'd0;
        end else if ((s.bo == 2'd1) && ((c == CH_PLUS) || (c == CH_MINUS))) begin
          r.st.bo         = 2'd2;
          r.st.sign_minus = (c == CH_MINUS);
        end else begin
          ends = 1'b1;
        end
      end
    endcase
    if (ends) begin
      r = push_then_start(s, mk_tok(ending_kind(s.mode), s.ts, len0), c, pos);
    end
    return r;
  endfunction

  // An exponent letter, and its sign, with no digit after them: the number
  // ends before the letter, and the letter and sign are rescanned as a
  // one-letter name and a plus or minus.
  function automatic step_t back_off(scan_st_t s, logic [LEN_W-1:0] p);
    step_t            r;
    logic [LEN_W-1:0] p_e;
    p_e       = p - {{(LEN_W-2){1'b0}}, s.bo};
    r.st      = s;
    r.n       = 2'd1;
    r.r0      = mk_tok(K_NUMBER, s.ts, p_e - {1'b0, s.ts});
    r.r1      = '0;
    r.st.bo   = 2'd0;
    r.st.ts   = p_e[POS_W-1:0];
    r.st.mode = s.exp_up ? M_UPPER : M_LNAME;
    if (s.bo == 2'd2) begin
      r.n       = 2'd2;
      r.r1      = mk_tok(s.exp_up ? K_ULETTER : K_LNAME, p_e[POS_W-1:0], LEN_W'(1));
      r.st.ts   = p_e[POS_W-1:0] + POS_W'(1);
      r.st.mode = s.sign_minus ? M_MINUS : M_PLUS;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic                in_vld_r;
  in_item_t            in_item_r;
  scan_st_t            st_r;
  scan_st_t            st_nxt;
  logic [LEN_W-1:0]    line_pos_r;
  logic [LEN_W-1:0]    line_pos_nxt;

  out_item_t           fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  head_r;
  logic [FIFO_AW-1:0]  tail_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;

  // Scan pass signals.
  logic                room;
  logic                proc;
  logic                pop;
  out_item_t           lst [PUSH_MAX];
  logic [2:0]          npush;
  scan_st_t            st_work;
  step_t               bo_step;
  step_t               sc_step;
  logic [7:0]          cur_c;
  logic [LEN_W-1:0]    len_end;
  logic [POS_W-1:0]    nop_pos;
  logic [POS_W-1:0]    fin_nop;

  // A held byte is scanned only when the queue can take its worst case.
  assign room      = (cnt_r <= CNT_W'(FIFO_DEPTH - PUSH_MAX));
  assign proc      = in_vld_r && room;
  assign in_ready  = !in_vld_r || room;
  assign out_valid = (cnt_r != '0);
  assign out_data  = fifo_r[head_r];
  assign pop       = out_valid && out_ready;
  assign cur_c     = in_item_r.char_code;

  // --------------------------------------------------------------------------
  // Scan pass: one byte or one end of line per cycle when the queue has room.
  // --------------------------------------------------------------------------
  always_comb begin
    st_nxt       = st_r;
    line_pos_nxt = line_pos_r;
    npush        = 3'd0;
    st_work      = st_r;
    bo_step      = '0;
    sc_step      = '0;
    len_end      = '0;
    fin_nop      = st_r.nop;
    nop_pos      = (line_pos_r > LEN_W'(MAX_LINE - 1)) ? POS_W'(MAX_LINE - 1)
                                                       : line_pos_r[POS_W-1:0];
    for (int i = 0; i < PUSH_MAX; i++) begin
      lst[i] = '0;
    end

    if (proc) begin
      if (in_item_r.end_of_line) begin
        // Close whatever is open, then report the line-closing Nop.
        if (!st_r.skip) begin
          if ((st_r.mode == M_EXP) && (st_r.bo != 2'd0)) begin
            bo_step    = back_off(st_r, line_pos_r);
            lst[0]     = bo_step.r0;
            lst[1]     = bo_step.r1;
            npush      = {1'b0, bo_step.n};
            st_work    = bo_step.st;
          end
          len_end = line_pos_r - {1'b0, st_work.ts};
          unique case (st_work.mode)
            M_IDLE: begin
              npush = npush;
            end
            M_STRING: begin
              lst[npush[1:0]] = mk_item(K_NOP, st_work.ts, len_end, DK_NUM, 16'd0,
                                        E_STRING, 1'b0);
              npush           = npush + 3'd1;
            end
            M_VAR0: begin
              lst[npush[1:0]] = mk_item(K_NOP, st_work.ts, len_end, DK_NUM, 16'd0,
                                        E_VAR, 1'b0);
              npush           = npush + 3'd1;
            end
            M_FUNC0: begin
              lst[npush[1:0]] = mk_item(K_NOP, st_work.ts, len_end, DK_NUM, 16'd0,
                                        E_FUNC, 1'b0);
              npush           = npush + 3'd1;
            end
            M_AT: begin
              lst[npush[1:0]] = mk_item(K_NOP, st_work.ts, len_end, DK_NUM, 16'd0,
                                        E_AT, 1'b0);
              npush           = npush + 3'd1;
            end
            M_ATNUM: begin
              lst[npush[1:0]] = mk_item(K_DATASET, st_work.ts, len_end, DK_NUM,
                                        st_work.acc, E_NONE, 1'b0);
              npush           = npush + 3'd1;
            end
            default: begin
              lst[npush[1:0]] = mk_tok(ending_kind(st_work.mode), st_work.ts, len_end);
              npush           = npush + 3'd1;
            end
          endcase
          fin_nop = nop_pos;
        end
        lst[npush[1:0]] = mk_item(K_NOP, fin_nop, '0, DK_NUM, 16'd0, E_NONE, 1'b1);
        npush           = npush + 3'd1;
        st_nxt          = ST_RESET;
        line_pos_nxt    = '0;
      end else if (line_pos_r < LEN_W'(MAX_LINE)) begin
        line_pos_nxt = line_pos_r + LEN_W'(1);
        if (!st_r.skip) begin
          // A pending exponent is backed off before the byte is scanned,
          // unless the byte continues it.
          if ((st_r.mode == M_EXP) && (st_r.bo != 2'd0) && !is_digit(cur_c) &&
              !((st_r.bo == 2'd1) && ((cur_c == CH_PLUS) || (cur_c == CH_MINUS)))) begin
            bo_step = back_off(st_r, line_pos_r);
            lst[0]  = bo_step.r0;
            lst[1]  = bo_step.r1;
            npush   = {1'b0, bo_step.n};
            st_work = bo_step.st;
          end
          sc_step = scan(st_work, cur_c, line_pos_r[POS_W-1:0]);
          if (sc_step.n != 2'd0) begin
            lst[npush[1:0]] = sc_step.r0;
            npush           = npush + 3'd1;
          end
          if (sc_step.n == 2'd2) begin
            lst[npush[1:0]] = sc_step.r1;
            npush           = npush + 3'd1;
          end
          st_nxt = sc_step.st;
        end
      end
    end
  end

  assign cnt_nxt = cnt_r + CNT_W'(npush) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      st_r       <= ST_RESET;
      line_pos_r <= '0;
      head_r     <= '0;
      tail_r     <= '0;
      cnt_r      <= '0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      st_r       <= st_nxt;
      line_pos_r <= line_pos_nxt;
      if (pop) begin
        head_r <= head_r + FIFO_AW'(1);
      end
      tail_r <= tail_r + FIFO_AW'(npush);
      cnt_r  <= cnt_nxt;
    end
  end

  // Payload storage: the input byte and the queued results.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    for (int i = 0; i < PUSH_MAX; i++) begin
      if (3'(i) < npush) begin
        fifo_r[tail_r + FIFO_AW'(i)] <= lst[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CLT_ASSERT_ALWAYS(a_queue_bound, cnt_r <= CNT_W'(FIFO_DEPTH))
  `CLT_ASSERT_IMPL(a_skip_is_idle, st_r.skip, st_r.mode == M_IDLE)
  `CLT_ASSERT_NEXT(a_line_restart, proc && in_item_r.end_of_line,
                   (line_pos_r == '0) && (st_r.mode == M_IDLE) && !st_r.skip)
  `CLT_ASSERT_NEXT(a_queue_hold, !proc && !pop, $stable(cnt_r) && $stable(tail_r))
  `CLT_ASSERT_IMPL(a_last_is_nop, out_valid && out_data.last_of_line,
                   (out_data.token_kind == K_NOP) && (out_data.token_length == '0))

endmodule
